FILE: src/upsp_pkg.sv
// ----------------------------------------------------------------------------
// UPS status reply parser package
// Beat types, field kinds, status codes and frame constants shared by the
// parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package upsp_pkg;

    localparam int FRAME_LEN = 47;

    localparam logic [5:0] LAST_POS = 6'(FRAME_LEN - 1);
    localparam logic [5:0] POS_MAX  = 6'd63;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LENGTH = 2'd1;
    localparam logic [1:0] ST_FORMAT = 2'd2;

    typedef enum logic [3:0] {
        FLD_START,
        FLD_SPACE,
        FLD_ZERO,
        FLD_DOT,
        FLD_CR,
        FLD_VIN,
        FLD_VOUT,
        FLD_LOAD,
        FLD_FREQ,
        FLD_BAT,
        FLD_BAT_A,
        FLD_BAT_B,
        FLD_TEMP,
        FLD_FLAG,
        FLD_NONE
    } field_kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } rx_item_t;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic [13:0] input_voltage_tenths;
        logic [13:0] output_voltage_tenths;
        logic [9:0]  load_percent;
        logic [9:0]  input_freq_tenths;
        logic [13:0] battery_voltage_hundredths;
        logic [9:0]  temperature_tenths;
        logic [7:0]  flag_bits;
    } res_item_t;

    typedef struct packed {
        field_kind_t kind;
        logic        digit_ok;
        logic [3:0]  digit;
        logic        is_dot;
        logic        is_one;
        logic [1:0]  fault;
    } byte_ctl_t;

endpackage

`default_nettype wire

FILE: src/upsp_byte_decode.sv
// ----------------------------------------------------------------------------
// Byte decoder
// Maps the frame position to a field kind and classifies the received byte
// against what that position expects.
// ----------------------------------------------------------------------------
`default_nettype none

module upsp_byte_decode
    import upsp_pkg::*;
(
    input  wire logic [5:0] pos,
    input  wire logic [7:0] rx_byte,
    output byte_ctl_t       ctl
);

    function automatic field_kind_t layout_kind(input logic [5:0] p);
        field_kind_t k;
        case (p)
            6'd0:                              k = FLD_START;
            6'd1, 6'd2, 6'd3, 6'd5:            k = FLD_VIN;
            6'd4, 6'd10, 6'd16, 6'd25, 6'd35:  k = FLD_DOT;
            6'd6, 6'd12, 6'd18, 6'd22, 6'd27,
            6'd32, 6'd37:                      k = FLD_SPACE;
            6'd7, 6'd8, 6'd9, 6'd11:           k = FLD_ZERO;
            6'd13, 6'd14, 6'd15, 6'd17:        k = FLD_VOUT;
            6'd19, 6'd20, 6'd21:               k = FLD_LOAD;
            6'd23, 6'd24, 6'd26:               k = FLD_FREQ;
            6'd28, 6'd31:                      k = FLD_BAT;
            6'd29:                             k = FLD_BAT_A;
            6'd30:                             k = FLD_BAT_B;
            6'd33, 6'd34, 6'd36:               k = FLD_TEMP;
            6'd38, 6'd39, 6'd40, 6'd41,
            6'd42, 6'd43, 6'd44, 6'd45:        k = FLD_FLAG;
            6'd46:                             k = FLD_CR;
            default:                           k = FLD_NONE;
        endcase
        return k;
    endfunction

    logic       digit_ok;
    logic [7:0] digit_full;

    assign digit_ok   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign digit_full = rx_byte - CH_ZERO;

    always_comb
    begin
        ctl.kind     = layout_kind(pos);
        ctl.digit_ok = digit_ok;
        ctl.digit    = digit_full[3:0];
        ctl.is_dot   = (rx_byte == CH_DOT);
        ctl.is_one   = (rx_byte == CH_ONE);
        ctl.fault    = ST_OK;
        case (ctl.kind)
            FLD_START: if (rx_byte != CH_OPEN)  ctl.fault = ST_LENGTH;
            FLD_SPACE: if (rx_byte != CH_SPACE) ctl.fault = ST_FORMAT;
            FLD_ZERO:  if (rx_byte != CH_ZERO)  ctl.fault = ST_FORMAT;
            FLD_DOT:   if (rx_byte != CH_DOT)   ctl.fault = ST_FORMAT;
            FLD_CR:    if (rx_byte != CH_CR)    ctl.fault = ST_FORMAT;
            FLD_VIN, FLD_VOUT, FLD_LOAD, FLD_FREQ, FLD_BAT, FLD_TEMP:
                if (!digit_ok) ctl.fault = ST_FORMAT;
            FLD_BAT_A:
                if (!ctl.is_dot && !digit_ok) ctl.fault = ST_FORMAT;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/upsp_field_accum.sv
// ----------------------------------------------------------------------------
// Field accumulator
// Holds the frame position, first error and decimal accumulators, updates
// them for each accepted beat and forms the result for the last beat.
// ----------------------------------------------------------------------------
`default_nettype none

module upsp_field_accum
    import upsp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      take,
    input  wire logic      frame_end,
    input  wire byte_ctl_t ctl,
    output logic [5:0]     pos,
    output logic           done,
    output res_item_t      result
);

    function automatic logic [13:0] acc_step(input logic [13:0] acc, input logic [3:0] d);
        return {acc[10:0], 3'b000} + {acc[12:0], 1'b0} + {10'd0, d};
    endfunction

    function automatic logic [9:0] acc_step10(input logic [9:0] acc, input logic [3:0] d);
        return {acc[6:0], 3'b000} + {acc[8:0], 1'b0} + {6'd0, d};
    endfunction

    logic [5:0]  pos_reg,  pos_next,  pos_upd;
    logic [1:0]  err_reg,  err_next,  err_upd;
    logic [13:0] vin_reg,  vin_next,  vin_upd;
    logic [13:0] vout_reg, vout_next, vout_upd;
    logic [9:0]  load_reg, load_next, load_upd;
    logic [9:0]  freq_reg, freq_next, freq_upd;
    logic [13:0] vbat_reg, vbat_next, vbat_upd;
    logic [9:0]  temp_reg, temp_next, temp_upd;
    logic [7:0]  flag_reg, flag_next, flag_upd;
    logic        two_reg,  two_next,  two_upd;
    logic [1:0]  fault;
    logic [1:0]  status;
    logic [13:0] vbat_out;

    always_comb
    begin
        vin_upd  = vin_reg;
        vout_upd = vout_reg;
        load_upd = load_reg;
        freq_upd = freq_reg;
        vbat_upd = vbat_reg;
        temp_upd = temp_reg;
        flag_upd = flag_reg;
        two_upd  = two_reg;
        fault    = ctl.fault;
        case (ctl.kind)
            FLD_VIN:  if (ctl.digit_ok) vin_upd  = acc_step(vin_reg, ctl.digit);
            FLD_VOUT: if (ctl.digit_ok) vout_upd = acc_step(vout_reg, ctl.digit);
            FLD_LOAD: if (ctl.digit_ok) load_upd = acc_step10(load_reg, ctl.digit);
            FLD_FREQ: if (ctl.digit_ok) freq_upd = acc_step10(freq_reg, ctl.digit);
            FLD_TEMP: if (ctl.digit_ok) temp_upd = acc_step10(temp_reg, ctl.digit);
            FLD_BAT:  if (ctl.digit_ok) vbat_upd = acc_step(vbat_reg, ctl.digit);
            FLD_BAT_A:
            begin
                if (ctl.is_dot)
                begin
                    two_upd = 1'b0;
                end
                else
                begin
                    two_upd = 1'b1;
                    if (ctl.digit_ok) vbat_upd = acc_step(vbat_reg, ctl.digit);
                end
            end
            FLD_BAT_B:
            begin
                if (two_reg)
                begin
                    if (!ctl.is_dot) fault = ST_FORMAT;
                end
                else if (ctl.digit_ok)
                begin
                    vbat_upd = acc_step(vbat_reg, ctl.digit);
                end
                else
                begin
                    fault = ST_FORMAT;
                end
            end
            FLD_FLAG: flag_upd = {flag_reg[6:0], ctl.is_one};
            default: ;
        endcase
        err_upd = (err_reg == ST_OK) ? fault : err_reg;
        pos_upd = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 6'd1;
    end

    always_comb
    begin
        status   = (pos_reg != LAST_POS) ? ST_LENGTH : err_upd;
        vbat_out = two_upd ? acc_step(vbat_upd, 4'd0) : vbat_upd;
        result   = '0;
        result.parse_status = status;
        if (status == ST_OK)
        begin
            result.input_voltage_tenths       = vin_upd;
            result.output_voltage_tenths      = vout_upd;
            result.load_percent               = load_upd;
            result.input_freq_tenths          = freq_upd;
            result.battery_voltage_hundredths = vbat_out;
            result.temperature_tenths         = temp_upd;
            result.flag_bits                  = flag_upd;
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        err_next  = err_reg;
        vin_next  = vin_reg;
        vout_next = vout_reg;
        load_next = load_reg;
        freq_next = freq_reg;
        vbat_next = vbat_reg;
        temp_next = temp_reg;
        flag_next = flag_reg;
        two_next  = two_reg;
        if (take && frame_end)
        begin
            pos_next  = '0;
            err_next  = ST_OK;
            vin_next  = '0;
            vout_next = '0;
            load_next = '0;
            freq_next = '0;
            vbat_next = '0;
            temp_next = '0;
            flag_next = '0;
            two_next  = 1'b0;
        end
        else if (take)
        begin
            pos_next  = pos_upd;
            err_next  = err_upd;
            vin_next  = vin_upd;
            vout_next = vout_upd;
            load_next = load_upd;
            freq_next = freq_upd;
            vbat_next = vbat_upd;
            temp_next = temp_upd;
            flag_next = flag_upd;
            two_next  = two_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            err_reg  <= ST_OK;
            vin_reg  <= '0;
            vout_reg <= '0;
            load_reg <= '0;
            freq_reg <= '0;
            vbat_reg <= '0;
            temp_reg <= '0;
            flag_reg <= '0;
            two_reg  <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            err_reg  <= err_next;
            vin_reg  <= vin_next;
            vout_reg <= vout_next;
            load_reg <= load_next;
            freq_reg <= freq_next;
            vbat_reg <= vbat_next;
            temp_reg <= temp_next;
            flag_reg <= flag_next;
            two_reg  <= two_next;
        end
    end

    assign pos  = pos_reg;
    assign done = take && frame_end;

endmodule

`default_nettype wire

FILE: src/upsp_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one finished result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module upsp_out_reg
    import upsp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire res_item_t load_data,
    output logic           free,
    output logic           res_valid,
    input  wire logic      res_ready,
    output res_item_t      res_data
);

    logic      valid_reg, valid_next;
    res_item_t data_reg,  data_next;

    assign free = !valid_reg || res_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

`default_nettype wire

FILE: src/ups_status_response_parser.sv
// A result beat is valid in the cycle after the last byte of a reply is accepted.
// Throughput: one byte per cycle while the result register is free; the position compare and one
// multiply-by-ten accumulate per byte fit between the state registers and the result register.
// A byte is taken whenever the result register is empty or being drained.
// Reset (rst_n, asynchronous, active low) clears position, error, accumulators and result valid.
// ----------------------------------------------------------------------------
// UPS status reply parser
// Parses the fixed 47-byte status reply into fixed-point readings and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ups_status_response_parser
    import upsp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     rx_valid,
    output logic          rx_ready,
    input  wire rx_item_t rx_data,
    output logic          res_valid,
    input  wire logic     res_ready,
    output res_item_t     res_data
);

    logic      free;
    logic      take;
    logic      done;
    logic [5:0] pos;
    byte_ctl_t ctl;
    res_item_t result;

    assign rx_ready = free;
    assign take     = rx_valid && free;

    upsp_byte_decode u_decode (
        .pos     (pos),
        .rx_byte (rx_data.rx_byte),
        .ctl     (ctl)
    );

    upsp_field_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .frame_end (rx_data.frame_end),
        .ctl       (ctl),
        .pos       (pos),
        .done      (done),
        .result    (result)
    );

    upsp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (done),
        .load_data (result),
        .free      (free),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire

FILE: src/upsp_checker.sv
// ----------------------------------------------------------------------------
// Parser port checker
// Checks result timing and result contents seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module upsp_checker
    import upsp_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      rx_valid,
    input wire logic      rx_ready,
    input wire rx_item_t  rx_data,
    input wire logic      res_valid,
    input wire logic      res_ready,
    input wire res_item_t res_data
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    a_res_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready && rx_data.frame_end |=> res_valid)
        else $error("no result beat after last byte");

    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rx_valid && rx_ready && rx_data.frame_end))
        else $error("result beat without a last byte");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.parse_status != ST_OK |->
            res_data.input_voltage_tenths == '0 && res_data.output_voltage_tenths == '0 &&
            res_data.load_percent == '0 && res_data.input_freq_tenths == '0 &&
            res_data.battery_voltage_hundredths == '0 &&
            res_data.temperature_tenths == '0 && res_data.flag_bits == '0)
        else $error("readings not cleared on error");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.parse_status == ST_OK || res_data.parse_status == ST_LENGTH ||
            res_data.parse_status == ST_FORMAT)
        else $error("unknown status code");

endmodule

bind ups_status_response_parser upsp_checker u_checker (.*);

`default_nettype wire

FILE: sim/tb_ups_status_response_parser.sv
// ----------------------------------------------------------------------------
// UPS status reply parser testbench
// Sends status replies byte by byte: clean 47-byte frames with random readings
// in both battery formats, frames with corrupted bytes, short and overlong
// frames, and raw noise. A predictor tracks the frame position, the first
// error and the digit accumulators, and each result beat is checked field by
// field against the oldest predicted reading. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_ups_status_response_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import upsp_pkg::*;

    localparam int ITEMS       = 2000;
    localparam int CYCLE_LIMIT = 400000;

    localparam int DIG_RANDOM = 0;
    localparam int DIG_ZERO   = 1;
    localparam int DIG_NINE   = 2;

    localparam int FL_MIXED = 0;
    localparam int FL_ONES  = 1;
    localparam int FL_ZEROS = 2;
    localparam int FL_JUNK  = 3;

    localparam int RDY_ALWAYS = 0;
    localparam int RDY_HALF   = 1;
    localparam int RDY_RARE   = 2;

    typedef struct {
        rx_item_t beat;
        bit       drain;
    } queued_beat_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      rx_valid = 1'b0;
    logic      rx_ready;
    rx_item_t  rx_data = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    res_item_t res_data;

    queued_beat_t byte_backlog[$];
    res_item_t    expected_readings[$];
    logic [7:0]   reply[$];

    logic        rx_fire = 1'b0;
    int          gap_left = 0;
    int          burst_left = 1;
    int          ready_mode = RDY_ALWAYS;
    int          mode_left = 0;
    int          cycle_count = 0;
    int          err_count = 0;
    int          beats_queued = 0;

    logic [5:0]  next_pos = '0;
    logic [1:0]  first_err = ST_OK;
    logic [13:0] vin_sum = '0;
    logic [13:0] vout_sum = '0;
    logic [9:0]  load_sum = '0;
    logic [9:0]  freq_sum = '0;
    logic [13:0] vbat_sum = '0;
    logic [9:0]  temp_sum = '0;
    logic [7:0]  flag_sh = '0;
    logic        bat_wide = 1'b0;

    ups_status_response_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_data   (rx_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic field_kind_t kind_at(input logic [5:0] p);
        case (p)
            0:                              return FLD_START;
            1, 2, 3, 5:                     return FLD_VIN;
            4, 10, 16, 25, 35:              return FLD_DOT;
            6, 12, 18, 22, 27, 32, 37:      return FLD_SPACE;
            7, 8, 9, 11:                    return FLD_ZERO;
            13, 14, 15, 17:                 return FLD_VOUT;
            19, 20, 21:                     return FLD_LOAD;
            23, 24, 26:                     return FLD_FREQ;
            28, 31:                         return FLD_BAT;
            29:                             return FLD_BAT_A;
            30:                             return FLD_BAT_B;
            33, 34, 36:                     return FLD_TEMP;
            38, 39, 40, 41, 42, 43, 44, 45: return FLD_FLAG;
            46:                             return FLD_CR;
            default:                        return FLD_NONE;
        endcase
    endfunction

    function automatic logic [13:0] dec_push(input logic [13:0] acc, input logic [7:0] b);
        return 14'(acc * 10 + (b - CH_ZERO));
    endfunction

    task automatic keep_first(input logic [1:0] code);
        if (first_err == ST_OK)
            first_err = code;
    endtask

    task automatic take_byte(input rx_item_t it);
        logic [7:0] b;
        logic       is_dig;
        logic       want_digit;
        logic       want_char;
        logic [7:0] char_needed;
        logic [5:0] at;
        res_item_t  r;
        b = it.rx_byte;
        is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
        want_digit = 1'b0;
        want_char = 1'b0;
        char_needed = CH_SPACE;
        at = next_pos;
        case (kind_at(at))
            FLD_START:
            begin
                if (b != CH_OPEN)
                    keep_first(ST_LENGTH);
            end
            FLD_SPACE: want_char = 1'b1;
            FLD_ZERO:
            begin
                want_char = 1'b1;
                char_needed = CH_ZERO;
            end
            FLD_DOT:
            begin
                want_char = 1'b1;
                char_needed = CH_DOT;
            end
            FLD_CR:
            begin
                want_char = 1'b1;
                char_needed = CH_CR;
            end
            FLD_VIN:
            begin
                want_digit = 1'b1;
                if (is_dig)
                    vin_sum = dec_push(vin_sum, b);
            end
            FLD_VOUT:
            begin
                want_digit = 1'b1;
                if (is_dig)
                    vout_sum = dec_push(vout_sum, b);
            end
            FLD_LOAD:
            begin
                want_digit = 1'b1;
                if (is_dig)
                    load_sum = 10'(dec_push(14'(load_sum), b));
            end
            FLD_FREQ:
            begin
                want_digit = 1'b1;
                if (is_dig)
                    freq_sum = 10'(dec_push(14'(freq_sum), b));
            end
            FLD_TEMP:
            begin
                want_digit = 1'b1;
                if (is_dig)
                    temp_sum = 10'(dec_push(14'(temp_sum), b));
            end
            FLD_BAT:
            begin
                want_digit = 1'b1;
                if (is_dig)
                    vbat_sum = dec_push(vbat_sum, b);
            end
            FLD_BAT_A:
            begin
                if (b == CH_DOT)
                    bat_wide = 1'b0;
                else
                begin
                    bat_wide = 1'b1;
                    want_digit = 1'b1;
                    if (is_dig)
                        vbat_sum = dec_push(vbat_sum, b);
                end
            end
            FLD_BAT_B:
            begin
                if (bat_wide)
                begin
                    want_char = 1'b1;
                    char_needed = CH_DOT;
                end
                else
                begin
                    want_digit = 1'b1;
                    if (is_dig)
                        vbat_sum = dec_push(vbat_sum, b);
                end
            end
            FLD_FLAG: flag_sh = {flag_sh[6:0], b == CH_ONE};
            default: ;
        endcase
        if ((want_digit && !is_dig) || (want_char && b != char_needed))
            keep_first(ST_FORMAT);
        if (next_pos != POS_MAX)
            next_pos = next_pos + 6'd1;
        if (it.frame_end)
        begin
            r = '0;
            r.parse_status = (at != LAST_POS) ? ST_LENGTH : first_err;
            if (r.parse_status == ST_OK)
            begin
                r.input_voltage_tenths = vin_sum;
                r.output_voltage_tenths = vout_sum;
                r.load_percent = load_sum;
                r.input_freq_tenths = freq_sum;
                r.battery_voltage_hundredths = bat_wide ? 14'(vbat_sum * 10) : vbat_sum;
                r.temperature_tenths = temp_sum;
                r.flag_bits = flag_sh;
            end
            expected_readings.push_back(r);
            next_pos = '0;
            first_err = ST_OK;
            vin_sum = '0;
            vout_sum = '0;
            load_sum = '0;
            freq_sum = '0;
            vbat_sum = '0;
            temp_sum = '0;
            flag_sh = '0;
            bat_wide = 1'b0;
        end
    endtask

    task automatic note_error(input string msg);
        err_count++;
        $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            note_error($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task automatic check_reading(input res_item_t got);
        res_item_t want;
        if (expected_readings.size() == 0)
            note_error($sformatf("result beat with none pending, status %0d",
                                 got.parse_status));
        else
        begin
            want = expected_readings.pop_front();
            check_field("parse_status", got.parse_status, want.parse_status);
            check_field("input_voltage_tenths", got.input_voltage_tenths,
                        want.input_voltage_tenths);
            check_field("output_voltage_tenths", got.output_voltage_tenths,
                        want.output_voltage_tenths);
            check_field("load_percent", got.load_percent, want.load_percent);
            check_field("input_freq_tenths", got.input_freq_tenths,
                        want.input_freq_tenths);
            check_field("battery_voltage_hundredths", got.battery_voltage_hundredths,
                        want.battery_voltage_hundredths);
            check_field("temperature_tenths", got.temperature_tenths,
                        want.temperature_tenths);
            check_field("flag_bits", got.flag_bits, want.flag_bits);
        end
    endtask

    task automatic make_reply(input int digits, input bit wide, input int flags);
        logic [7:0] d;
        logic [7:0] f;
        reply.delete();
        for (int p = 0; p < FRAME_LEN; p++)
        begin
            case (digits)
                DIG_ZERO: d = CH_ZERO;
                DIG_NINE: d = CH_NINE;
                default:  d = 8'(CH_ZERO + $urandom_range(0, 9));
            endcase
            case (flags)
                FL_ONES:  f = CH_ONE;
                FL_ZEROS: f = CH_ZERO;
                FL_JUNK:  f = 8'($urandom_range(0, 255));
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                        f = 8'($urandom_range(0, 255));
                    else
                        f = $urandom_range(0, 1) ? CH_ONE : CH_ZERO;
                end
            endcase
            case (kind_at(6'(p)))
                FLD_START: reply.push_back(CH_OPEN);
                FLD_SPACE: reply.push_back(CH_SPACE);
                FLD_ZERO:  reply.push_back(CH_ZERO);
                FLD_DOT:   reply.push_back(CH_DOT);
                FLD_CR:    reply.push_back(CH_CR);
                FLD_BAT_A: reply.push_back(wide ? d : CH_DOT);
                FLD_BAT_B: reply.push_back(wide ? CH_DOT : d);
                FLD_FLAG:  reply.push_back(f);
                default:   reply.push_back(d);
            endcase
        end
    endtask

    task automatic queue_reply(input bit drain);
        queued_beat_t e;
        for (int i = 0; i < reply.size(); i++)
        begin
            e.beat.rx_byte = reply[i];
            e.beat.frame_end = (i == reply.size() - 1);
            e.drain = drain && (i == 0);
            byte_backlog.push_back(e);
            beats_queued++;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n && (!rx_valid || rx_fire))
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                rx_valid <= 1'b0;
            end
            else if (byte_backlog.size() != 0 &&
                     !(byte_backlog[0].drain && expected_readings.size() != 0))
            begin
                rx_data <= byte_backlog[0].beat;
                rx_valid <= 1'b1;
                void'(byte_backlog.pop_front());
                if (burst_left > 1)
                    burst_left = burst_left - 1;
                else
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
                rx_valid <= 1'b0;
        end
    end

    // Receiver: switches between always ready, coin-flip and mostly stalled.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(RDY_ALWAYS, RDY_RARE);
                mode_left = $urandom_range(20, 400);
            end
            else
                mode_left = mode_left - 1;
            case (ready_mode)
                RDY_ALWAYS: res_ready <= 1'b1;
                RDY_HALF:   res_ready <= 1'($urandom_range(0, 1));
                default:    res_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count = cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb_ups_status_response_parser: done, errors");
                $finish;
            end
            else
            begin
                if (res_valid && res_ready)
                    check_reading(res_data);
                if (rx_valid && rx_ready)
                    take_byte(rx_data);
                rx_fire <= rx_valid && rx_ready;
            end
        end
    end

    initial
    begin
        int pick;
        int n;
        bit drained_mid;
        drained_mid = 1'b0;

        make_reply(DIG_ZERO, 1'b0, FL_ZEROS);
        queue_reply(1'b0);
        make_reply(DIG_NINE, 1'b1, FL_ONES);
        queue_reply(1'b0);
        make_reply(DIG_NINE, 1'b0, FL_JUNK);
        queue_reply(1'b0);
        make_reply(DIG_ZERO, 1'b1, FL_MIXED);
        queue_reply(1'b0);
        make_reply(DIG_RANDOM, 1'b0, FL_MIXED);
        reply[0] = 8'h29;
        queue_reply(1'b0);
        make_reply(DIG_RANDOM, 1'b1, FL_MIXED);
        reply[1] = 8'h3A;
        queue_reply(1'b0);
        make_reply(DIG_RANDOM, 1'b0, FL_MIXED);
        reply[2] = 8'h2F;
        queue_reply(1'b0);
        make_reply(DIG_RANDOM, 1'b0, FL_MIXED);
        reply[6] = 8'h5F;
        queue_reply(1'b0);
        make_reply(DIG_RANDOM, 1'b1, FL_MIXED);
        reply[9] = CH_ONE;
        queue_reply(1'b0);
        make_reply(DIG_RANDOM, 1'b0, FL_MIXED);
        reply[25] = 8'h2C;
        queue_reply(1'b0);
        make_reply(DIG_RANDOM, 1'b1, FL_MIXED);
        reply[46] = 8'h0A;
        queue_reply(1'b0);
        // Narrow battery layout with a digit where the dot belongs.
        make_reply(DIG_RANDOM, 1'b0, FL_MIXED);
        reply[29] = 8'h35;
        queue_reply(1'b0);
        make_reply(DIG_RANDOM, 1'b0, FL_MIXED);
        reply[29] = 8'h41;
        queue_reply(1'b0);
        // A bad start byte wins over a later field error.
        make_reply(DIG_RANDOM, 1'b1, FL_MIXED);
        reply[0] = 8'h00;
        reply[3] = 8'hFF;
        queue_reply(1'b0);
        make_reply(DIG_RANDOM, 1'b0, FL_MIXED);
        void'(reply.pop_back());
        queue_reply(1'b0);
        make_reply(DIG_RANDOM, 1'b1, FL_MIXED);
        reply.push_back(CH_CR);
        queue_reply(1'b0);
        // Long enough to saturate the position counter.
        make_reply(DIG_RANDOM, 1'b0, FL_MIXED);
        repeat (25) reply.push_back(8'($urandom_range(0, 255)));
        queue_reply(1'b0);
        reply.delete();
        reply.push_back(CH_OPEN);
        queue_reply(1'b0);

        make_reply(DIG_RANDOM, 1'($urandom_range(0, 1)), FL_MIXED);
        queue_reply(1'b1);
        while (beats_queued < ITEMS)
        begin
            pick = $urandom_range(0, 99);
            make_reply(($urandom_range(0, 9) == 0) ? $urandom_range(DIG_ZERO, DIG_NINE)
                                                   : DIG_RANDOM,
                       1'($urandom_range(0, 1)),
                       ($urandom_range(0, 5) == 0) ? FL_JUNK : FL_MIXED);
            if (pick < 60)
                ;
            else if (pick < 78)
                reply[$urandom_range(0, FRAME_LEN - 1)] = 8'($urandom_range(0, 255));
            else if (pick < 86)
            begin
                n = $urandom_range(1, FRAME_LEN - 1);
                repeat (n) void'(reply.pop_back());
            end
            else if (pick < 93)
            begin
                n = $urandom_range(1, 40);
                repeat (n) reply.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                reply.delete();
                n = $urandom_range(1, 40);
                repeat (n) reply.push_back(8'($urandom_range(0, 255)));
            end
            if (pick >= 93 && $urandom_range(0, 1) == 0)
            begin
                // Noise that ends a frame only at randomly chosen bytes and runs into the next one.
                for (int i = 0; i < reply.size(); i++)
                begin
                    byte_backlog.push_back('{beat: '{rx_byte: reply[i],
                                                    frame_end: ($urandom_range(0, 15) == 0)},
                                             drain: 1'b0});
                    beats_queued++;
                end
            end
            else
            begin
                queue_reply(!drained_mid && beats_queued >= ITEMS / 2);
                if (beats_queued >= ITEMS / 2)
                    drained_mid = 1'b1;
            end
        end
        make_reply(DIG_RANDOM, 1'b1, FL_MIXED);
        queue_reply(1'b0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (byte_backlog.size() != 0 || rx_valid || expected_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("tb_ups_status_response_parser: done, clean");
        else
            $display("tb_ups_status_response_parser: done, errors");
        $finish;
    end

endmodule

FILE: ups_status_response_parser.f
src/upsp_pkg.sv
src/upsp_byte_decode.sv
src/upsp_field_accum.sv
src/upsp_out_reg.sv
src/ups_status_response_parser.sv
src/upsp_checker.sv
sim/tb_ups_status_response_parser.sv
